/* design/kws_pkg.sv */
// kws_pkg: shared types and constants of the keyword substitution cipher
// used by kws_ram, kws_seq and keyword_substitution_cipher; no dependencies
package kws_pkg;

  localparam int ALPHABET_LETTERS = 26;
  localparam int IDX_W = $clog2(ALPHABET_LETTERS);

  // command codes
  localparam logic [2:0] FN_CLEAR  = 3'd0;
  localparam logic [2:0] FN_KEY    = 3'd1;
  localparam logic [2:0] FN_FINISH = 3'd2;
  localparam logic [2:0] FN_ENC    = 3'd3;
  localparam logic [2:0] FN_DEC    = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_IGNORED   = 2'd1;
  localparam logic [1:0] STAT_NOT_READY = 2'd2;

  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UZ = 8'h5a;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7a;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHABET_LETTERS - 1);
  localparam logic [IDX_W:0]   FULL_POS = (IDX_W + 1)'(ALPHABET_LETTERS);

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
  } kws_cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
  } kws_res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } kws_ram_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_READ,
    S_RESP
  } kws_state_t;

endpackage

/* design/kws_ram.sv */
// kws_ram: one 26-entry letter table, one write port and one registered read port
// depends on kws_pkg
module kws_ram (
  input  logic                      clk,
  input  kws_pkg::kws_ram_req_t     req,
  output logic [kws_pkg::IDX_W-1:0] rd_data
);

  logic [kws_pkg::IDX_W-1:0] mem [kws_pkg::ALPHABET_LETTERS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

/* design/kws_seq.sv */
// kws_seq: command sequencer, key state, shared letter placement unit and result register
// depends on kws_pkg; drives the two kws_ram tables
module kws_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  kws_pkg::kws_cmd_t         cmd,
  output logic                      res_valid,
  input  logic                      res_ready,
  output kws_pkg::kws_res_t         res,
  output kws_pkg::kws_ram_req_t     fwd_req,
  output kws_pkg::kws_ram_req_t     inv_req,
  input  logic [kws_pkg::IDX_W-1:0] fwd_rd,
  input  logic [kws_pkg::IDX_W-1:0] inv_rd
);

  kws_pkg::kws_state_t state, state_next;

  logic [2:0]                        func;
  logic [7:0]                        data_byte;
  logic [kws_pkg::ALPHABET_LETTERS-1:0] letter_used;
  logic [kws_pkg::IDX_W:0]           fill_position;
  logic                              key_ready;
  logic [kws_pkg::IDX_W-1:0]         walk;
  logic [7:0]                        pend_byte;
  logic [1:0]                        pend_status;

  logic                      is_upper, is_lower, is_letter;
  logic [kws_pkg::IDX_W-1:0] li;
  logic                      do_place, place_go;
  logic [kws_pkg::IDX_W-1:0] place_idx;
  logic                      clear_key, set_ready, pend_load, res_load;
  logic [7:0]                pend_byte_next;
  logic [1:0]                pend_status_next;

  // letter decode of the held word
  always_comb begin
    is_upper = (data_byte >= kws_pkg::CHAR_UA) && (data_byte <= kws_pkg::CHAR_UZ);
    is_lower = (data_byte >= kws_pkg::CHAR_LA) && (data_byte <= kws_pkg::CHAR_LZ);
    is_letter = is_upper || is_lower;
    if (is_lower) begin
      li = kws_pkg::IDX_W'(data_byte - kws_pkg::CHAR_LA);
    end else begin
      li = kws_pkg::IDX_W'(data_byte - kws_pkg::CHAR_UA);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      kws_pkg::S_IDLE: begin
        if (cmd_valid) state_next = kws_pkg::S_EXEC;
      end
      kws_pkg::S_EXEC: begin
        state_next = kws_pkg::S_RESP;
        if (func == kws_pkg::FN_FINISH && !key_ready) begin
          state_next = kws_pkg::S_FILL;
        end else if ((func == kws_pkg::FN_ENC || func == kws_pkg::FN_DEC)
                     && key_ready && is_letter) begin
          state_next = kws_pkg::S_READ;
        end
      end
      kws_pkg::S_FILL: begin
        if (walk == kws_pkg::LAST_IDX) state_next = kws_pkg::S_RESP;
      end
      kws_pkg::S_READ: state_next = kws_pkg::S_RESP;
      kws_pkg::S_RESP: begin
        if (!res_valid || res_ready) state_next = kws_pkg::S_IDLE;
      end
      default: state_next = kws_pkg::S_IDLE;
    endcase
  end

  // outputs and enables
  always_comb begin
    cmd_ready        = (state == kws_pkg::S_IDLE);
    do_place         = 1'b0;
    clear_key        = 1'b0;
    set_ready        = 1'b0;
    pend_load        = 1'b0;
    pend_byte_next   = 8'd0;
    pend_status_next = kws_pkg::STAT_OK;
    res_load         = 1'b0;
    case (state)
      kws_pkg::S_EXEC: begin
        pend_load = 1'b1;
        case (func)
          kws_pkg::FN_CLEAR: clear_key = 1'b1;
          kws_pkg::FN_KEY: begin
            if (key_ready || !is_letter) begin
              pend_status_next = kws_pkg::STAT_IGNORED;
            end else begin
              do_place = 1'b1;
            end
          end
          kws_pkg::FN_FINISH: begin
            if (key_ready) pend_status_next = kws_pkg::STAT_IGNORED;
          end
          kws_pkg::FN_ENC, kws_pkg::FN_DEC: begin
            if (!key_ready) begin
              pend_status_next = kws_pkg::STAT_NOT_READY;
            end else if (!is_letter) begin
              pend_byte_next = data_byte;
            end
          end
          default: pend_status_next = kws_pkg::STAT_IGNORED;
        endcase
      end
      kws_pkg::S_FILL: begin
        do_place  = 1'b1;
        set_ready = (walk == kws_pkg::LAST_IDX);
      end
      kws_pkg::S_READ: begin
        pend_load = 1'b1;
        if (func == kws_pkg::FN_ENC) begin
          pend_byte_next = kws_pkg::CHAR_UA + 8'(fwd_rd);
        end else begin
          pend_byte_next = kws_pkg::CHAR_UA + 8'(inv_rd);
        end
      end
      kws_pkg::S_RESP: res_load = !res_valid || res_ready;
      default: ;
    endcase

    // shared placement unit: keyword letter or the next letter of the walk
    place_idx = (state == kws_pkg::S_FILL) ? walk : li;
    place_go  = do_place && (fill_position < kws_pkg::FULL_POS)
                && !letter_used[place_idx];

    fwd_req.we    = place_go;
    fwd_req.waddr = fill_position[kws_pkg::IDX_W-1:0];
    fwd_req.wdata = place_idx;
    fwd_req.raddr = li;
    inv_req.we    = place_go;
    inv_req.waddr = place_idx;
    inv_req.wdata = fill_position[kws_pkg::IDX_W-1:0];
    inv_req.raddr = li;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= kws_pkg::S_IDLE;
      letter_used   <= '0;
      fill_position <= '0;
      key_ready     <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (clear_key) begin
        letter_used   <= '0;
        fill_position <= '0;
        key_ready     <= 1'b0;
      end else begin
        if (place_go) begin
          letter_used[place_idx] <= 1'b1;
          fill_position          <= fill_position + 1'b1;
        end
        if (set_ready) key_ready <= 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      func      <= cmd.func;
      data_byte <= cmd.data_byte;
    end
    if (state == kws_pkg::S_EXEC) begin
      walk <= '0;
    end else if (state == kws_pkg::S_FILL) begin
      walk <= walk + 1'b1;
    end
    if (pend_load) begin
      pend_byte   <= pend_byte_next;
      pend_status <= pend_status_next;
    end
    if (res_load) begin
      res.out_byte <= pend_byte;
      res.status   <= pend_status;
    end
  end

endmodule

/* design/keyword_substitution_cipher.sv */
// keyword_substitution_cipher: top level, sequencer plus forward and inverse tables
// depends on kws_pkg, kws_ram, kws_seq
//
//   port group   dir  payload     handshake
//   cmd          in   kws_cmd_t   cmd_valid / cmd_ready
//   res          out  kws_res_t   res_valid / res_ready
//
// one command in flight: key commands pass through the exec and resp states, encrypt
// and decrypt of a letter with a finished key add a read state (one registered table
// read), other text bytes skip it, and a finish on an unfinished key adds a fill state
// in which the placement unit walks the 26 letters one per cycle
// reset clears the key state; tables hold nothing defined until key commands and a finish fill them
// a result waits in the output register while res_ready is low; the next
// command is taken only once that result has been loaded
module keyword_substitution_cipher (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  kws_pkg::kws_cmd_t cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output kws_pkg::kws_res_t res
);

  kws_pkg::kws_ram_req_t     fwd_req, inv_req;
  logic [kws_pkg::IDX_W-1:0] fwd_rd, inv_rd;

  kws_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .fwd_req   (fwd_req),
    .inv_req   (inv_req),
    .fwd_rd    (fwd_rd),
    .inv_rd    (inv_rd)
  );

  // position -> letter
  kws_ram u_fwd (
    .clk     (clk),
    .req     (fwd_req),
    .rd_data (fwd_rd)
  );

  // letter -> position
  kws_ram u_inv (
    .clk     (clk),
    .req     (inv_req),
    .rd_data (inv_rd)
  );

endmodule
